@@ design/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SLSB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SLSB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/slsb_pkg.sv @@
package slsb_pkg;

    localparam logic [31:0] RETRY_INITIAL_RST = 32'd1000;
    localparam logic [31:0] BACKOFF_MAX_RST   = 32'd60000;
    localparam logic [31:0] SAMPLE_PERIOD_RST = 32'd20;

    localparam logic [7:0]  FATAL_FAULTS   = 8'd8;
    localparam logic [7:0]  READ_FAIL_CODE = 8'd8;
    localparam logic [7:0]  COUNT_MAX      = 8'hFF;

    localparam logic [1:0]  CFG_IDX_RETRY_INITIAL = 2'd0;
    localparam logic [1:0]  CFG_IDX_BACKOFF_MAX   = 2'd1;
    localparam logic [1:0]  CFG_IDX_SAMPLE_PERIOD = 2'd2;

    localparam logic        CMD_TICK  = 1'b0;
    localparam logic        CMD_FORCE = 1'b1;

    typedef enum logic [2:0] {
        RT_UNINIT      = 3'd0,
        RT_INITING     = 3'd1,
        RT_READY       = 3'd2,
        RT_CALIBRATING = 3'd3,
        RT_DEGRADED    = 3'd4,
        RT_BACKOFF     = 3'd5,
        RT_FATAL       = 3'd6
    } t_runtime;

    typedef struct packed {
        logic [31:0] retry_initial_ms;
        logic [31:0] backoff_max_ms;
        logic [31:0] sample_period_ms;
    } t_cfg;

    typedef struct packed {
        t_runtime    health_state;
        logic        link_online;
        logic [7:0]  fault_code;
        logic [7:0]  faults_seen;
        logic [7:0]  reinits_seen;
        logic [31:0] backoff_now_ms;
        logic [31:0] offline_stamp_ms;
        logic        sample_taken;
        logic [31:0] publish_seq;
    } t_result;

    function automatic logic [7:0] sat_inc8(input logic [7:0] value);
        return (value < COUNT_MAX) ? value + 8'd1 : value;
    endfunction

endpackage

@@ design/sensor_link_supervisor_backoff_top.sv @@
// the result of an input transfer is registered in the output register, or in the skid register while the output stalls
// throughput: one item per cycle while o_in_stall is low, all supervisor state updates in a single registered step
// an output register plus a skid register let input transfers continue while a result waits
// reset: synchronous, active low; clears supervisor state, counters and output valids
// and loads the configuration registers with their default values
module sensor_link_supervisor_backoff_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_command,
    input  logic [31:0] i_now_ms,
    input  logic        i_init_ok,
    input  logic [7:0]  i_init_error,
    input  logic        i_read_ok,
    input  logic        i_cal_pending,
    input  logic        i_cal_done,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_health_state,
    output logic        o_link_online,
    output logic [7:0]  o_fault_code,
    output logic [7:0]  o_faults_seen,
    output logic [7:0]  o_reinits_seen,
    output logic [31:0] o_backoff_now_ms,
    output logic [31:0] o_offline_stamp_ms,
    output logic        o_sample_taken,
    output logic [31:0] o_publish_seq
);
    import slsb_pkg::*;

    t_cfg    r_cfg;
    t_result result;
    t_result r_out;
    t_result r_skid;
    logic    r_out_valid;
    logic    r_skid_valid;
    logic    in_xfer;
    logic    out_free;

    assign in_xfer  = i_in_valid && !r_skid_valid;
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.retry_initial_ms <= RETRY_INITIAL_RST;
            r_cfg.backoff_max_ms   <= BACKOFF_MAX_RST;
            r_cfg.sample_period_ms <= SAMPLE_PERIOD_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                CFG_IDX_RETRY_INITIAL: r_cfg.retry_initial_ms <= i_cfg_wdata;
                CFG_IDX_BACKOFF_MAX:   r_cfg.backoff_max_ms   <= i_cfg_wdata;
                CFG_IDX_SAMPLE_PERIOD: r_cfg.sample_period_ms <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    slsb_engine u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_xfer),
        .i_cfg         (r_cfg),
        .i_command     (i_command),
        .i_now_ms      (i_now_ms),
        .i_init_ok     (i_init_ok),
        .i_init_error  (i_init_error),
        .i_read_ok     (i_read_ok),
        .i_cal_pending (i_cal_pending),
        .i_cal_done    (i_cal_done),
        .o_result      (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (out_free) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_out        <= r_skid;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= in_xfer;
                    if (in_xfer) begin
                        r_out <= result;
                    end
                end
            end else if (in_xfer) begin
                r_skid_valid <= 1'b1;
                r_skid       <= result;
            end
        end
    end

    assign o_in_stall         = r_skid_valid;
    assign o_out_valid        = r_out_valid;
    assign o_health_state     = r_out.health_state;
    assign o_link_online      = r_out.link_online;
    assign o_fault_code       = r_out.fault_code;
    assign o_faults_seen      = r_out.faults_seen;
    assign o_reinits_seen     = r_out.reinits_seen;
    assign o_backoff_now_ms   = r_out.backoff_now_ms;
    assign o_offline_stamp_ms = r_out.offline_stamp_ms;
    assign o_sample_taken     = r_out.sample_taken;
    assign o_publish_seq      = r_out.publish_seq;

endmodule

@@ design/slsb_engine.sv @@
module slsb_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  slsb_pkg::t_cfg     i_cfg,
    input  logic               i_command,
    input  logic [31:0]        i_now_ms,
    input  logic               i_init_ok,
    input  logic [7:0]         i_init_error,
    input  logic               i_read_ok,
    input  logic               i_cal_pending,
    input  logic               i_cal_done,
    output slsb_pkg::t_result  o_result
);
    import slsb_pkg::*;

    typedef enum logic [1:0] {
        PH_COLD    = 2'd0,
        PH_INITING = 2'd1,
        PH_ONLINE  = 2'd2,
        PH_BACKOFF = 2'd3
    } t_phase;

    t_phase      r_phase, n_phase;
    logic        r_is_init, n_is_init;
    logic        r_is_online, n_is_online;
    logic [7:0]  r_last_fault, n_last_fault;
    logic [7:0]  r_fault_total, n_fault_total;
    logic [7:0]  r_reinit_total, n_reinit_total;
    logic [31:0] r_backoff, n_backoff;
    logic [31:0] r_last_try, n_last_try;
    logic [31:0] r_last_sample, n_last_sample;
    logic [31:0] r_offline_since, n_offline_since;
    logic        r_offline_held, n_offline_held;
    logic [31:0] r_update_count, n_update_count;

    logic        taken;
    logic        do_sample;
    logic [31:0] try_delta;
    logic [31:0] sample_delta;
    logic [32:0] doubled;
    t_runtime    runtime;

    always_comb begin
        n_phase         = r_phase;
        n_is_init       = r_is_init;
        n_is_online     = r_is_online;
        n_last_fault    = r_last_fault;
        n_fault_total   = r_fault_total;
        n_reinit_total  = r_reinit_total;
        n_backoff       = r_backoff;
        n_last_try      = r_last_try;
        n_last_sample   = r_last_sample;
        n_offline_since = r_offline_since;
        n_offline_held  = r_offline_held;
        n_update_count  = r_update_count;
        taken           = 1'b0;
        do_sample       = 1'b0;
        try_delta       = i_now_ms - r_last_try;
        sample_delta    = i_now_ms - r_last_sample;
        doubled         = {r_backoff, 1'b0};

        if (i_command == CMD_FORCE) begin
            n_is_init      = 1'b0;
            n_is_online    = 1'b0;
            n_last_try     = '0;
            n_backoff      = i_cfg.retry_initial_ms;
            n_update_count = r_update_count + 32'd1;
            n_phase        = PH_INITING;
            if (!i_init_ok) begin
                n_last_fault = i_init_error;
            end else begin
                n_is_init       = 1'b1;
                n_is_online     = 1'b1;
                n_phase         = PH_ONLINE;
                n_last_fault    = '0;
                n_offline_since = '0;
                n_offline_held  = 1'b0;
                n_reinit_total  = sat_inc8(r_reinit_total);
            end
        end else begin
            if (!r_is_init) begin
                if (try_delta >= r_backoff) begin
                    n_last_try = i_now_ms;
                    if (!i_init_ok) begin
                        // failed retry: offline, then grow the backoff
                        n_is_online    = 1'b0;
                        n_is_init      = 1'b0;
                        n_phase        = PH_BACKOFF;
                        n_last_fault   = i_init_error;
                        n_fault_total  = sat_inc8(r_fault_total);
                        n_update_count = r_update_count + 32'd1;
                        if (!r_offline_held) begin
                            n_offline_held  = 1'b1;
                            n_offline_since = i_now_ms;
                        end
                        if (r_backoff < i_cfg.backoff_max_ms) begin
                            n_backoff = (doubled > {1'b0, i_cfg.backoff_max_ms}) ?
                                        i_cfg.backoff_max_ms : doubled[31:0];
                        end
                    end else begin
                        n_is_init       = 1'b1;
                        n_is_online     = 1'b1;
                        n_phase         = PH_ONLINE;
                        n_last_fault    = '0;
                        n_backoff       = i_cfg.retry_initial_ms;
                        n_offline_since = '0;
                        n_offline_held  = 1'b0;
                        n_reinit_total  = sat_inc8(r_reinit_total);
                        do_sample       = 1'b1;
                    end
                end
            end else begin
                do_sample = 1'b1;
            end

            if (do_sample && (sample_delta >= i_cfg.sample_period_ms)) begin
                if (!i_read_ok) begin
                    n_is_online    = 1'b0;
                    n_is_init      = 1'b0;
                    n_phase        = PH_BACKOFF;
                    n_last_fault   = READ_FAIL_CODE;
                    n_fault_total  = sat_inc8(n_fault_total);
                    n_update_count = n_update_count + 32'd1;
                    if (!n_offline_held) begin
                        n_offline_held  = 1'b1;
                        n_offline_since = i_now_ms;
                    end
                end else begin
                    n_is_online    = 1'b1;
                    n_last_fault   = '0;
                    n_last_sample  = i_now_ms;
                    n_update_count = n_update_count + 32'd1;
                    taken          = 1'b1;
                end
            end
        end
    end

    always_comb begin
        case (n_phase)
            PH_INITING: runtime = RT_INITING;
            PH_BACKOFF: begin
                if ((n_fault_total >= FATAL_FAULTS) && (n_backoff >= i_cfg.backoff_max_ms)) begin
                    runtime = RT_FATAL;
                end else begin
                    runtime = RT_BACKOFF;
                end
            end
            PH_ONLINE: begin
                if (!n_is_online) begin
                    runtime = RT_UNINIT;
                end else if (i_cal_pending) begin
                    runtime = RT_CALIBRATING;
                end else if (!i_cal_done) begin
                    runtime = RT_DEGRADED;
                end else begin
                    runtime = RT_READY;
                end
            end
            default: runtime = RT_UNINIT;
        endcase
    end

    always_comb begin
        o_result.health_state     = runtime;
        o_result.link_online      = n_is_online;
        o_result.fault_code       = n_last_fault;
        o_result.faults_seen      = n_fault_total;
        o_result.reinits_seen     = n_reinit_total;
        o_result.backoff_now_ms   = n_backoff;
        o_result.offline_stamp_ms = n_offline_since;
        o_result.sample_taken     = taken;
        o_result.publish_seq      = n_update_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_COLD;
            r_is_init       <= 1'b0;
            r_is_online     <= 1'b0;
            r_last_fault    <= '0;
            r_fault_total   <= '0;
            r_reinit_total  <= '0;
            r_backoff       <= RETRY_INITIAL_RST;
            r_last_try      <= '0;
            r_last_sample   <= '0;
            r_offline_since <= '0;
            r_offline_held  <= 1'b0;
            r_update_count  <= '0;
        end else if (i_accept) begin
            r_phase         <= n_phase;
            r_is_init       <= n_is_init;
            r_is_online     <= n_is_online;
            r_last_fault    <= n_last_fault;
            r_fault_total   <= n_fault_total;
            r_reinit_total  <= n_reinit_total;
            r_backoff       <= n_backoff;
            r_last_try      <= n_last_try;
            r_last_sample   <= n_last_sample;
            r_offline_since <= n_offline_since;
            r_offline_held  <= n_offline_held;
            r_update_count  <= n_update_count;
        end
    end

endmodule

@@ design/slsb_checker.sv @@
`include "assert_macros.svh"

module slsb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [2:0]  o_health_state,
    input logic        o_link_online,
    input logic [7:0]  o_fault_code,
    input logic [7:0]  o_faults_seen,
    input logic [31:0] o_offline_stamp_ms,
    input logic        o_sample_taken,
    input logic [31:0] o_publish_seq
);
    import slsb_pkg::*;

    logic        out_held;
    logic        out_online;
    logic        out_sample;
    logic        out_fatal;
    logic        stamp_clear;
    logic        sample_healthy;
    logic        fatal_history;
    logic [35:0] held_view;

    assign out_held       = o_out_valid && i_out_stall;
    assign out_online     = o_out_valid && o_link_online;
    assign out_sample     = o_out_valid && o_sample_taken;
    assign out_fatal      = o_out_valid && (o_health_state == RT_FATAL);
    assign stamp_clear    = (o_offline_stamp_ms == 32'd0);
    assign sample_healthy = o_link_online && (o_fault_code == 8'd0) &&
                            (o_health_state inside {RT_READY, RT_CALIBRATING, RT_DEGRADED});
    assign fatal_history  = !o_link_online && (o_faults_seen >= FATAL_FAULTS);
    assign held_view      = {o_out_valid, o_health_state, o_publish_seq};

    // stalled result holds
    `SLSB_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_held, $stable(held_view), "held result moved")

    // an online link has no offline stamp
    `SLSB_ASSERT_IMP(a_online_stamp, i_clk, i_rst_n, out_online, stamp_clear, "stamp while online")

    // a sample only comes from a healthy online link
    `SLSB_ASSERT_IMP(a_sample_ok, i_clk, i_rst_n, out_sample, sample_healthy, "unhealthy sample")

    // fatal needs enough faults and an offline link
    `SLSB_ASSERT_IMP(a_fatal, i_clk, i_rst_n, out_fatal, fatal_history, "fatal without faults")

endmodule

bind sensor_link_supervisor_backoff_top slsb_checker u_slsb_checker (.*);

@@ tb/slsb_supervisor_checker.sv @@
module slsb_supervisor_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic        i_command,
    input  logic [31:0] i_now_ms,
    input  logic        i_init_ok,
    input  logic [7:0]  i_init_error,
    input  logic        i_read_ok,
    input  logic        i_cal_pending,
    input  logic        i_cal_done,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [2:0]  i_health_state,
    input  logic        i_link_online,
    input  logic [7:0]  i_fault_code,
    input  logic [7:0]  i_faults_seen,
    input  logic [7:0]  i_reinits_seen,
    input  logic [31:0] i_backoff_now_ms,
    input  logic [31:0] i_offline_stamp_ms,
    input  logic        i_sample_taken,
    input  logic [31:0] i_publish_seq,
    output int          o_fail_count,
    output int          o_outstanding,
    output int          o_checked,
    output int          o_fatal_reports,
    output int          o_samples
);
    timeunit 1ns;
    timeprecision 1ps;

    import slsb_pkg::*;

    typedef enum logic [1:0] {
        PHASE_COLD    = 2'd0,
        PHASE_INITING = 2'd1,
        PHASE_ONLINE  = 2'd2,
        PHASE_BACKOFF = 2'd3
    } t_link_phase;

    // register copies
    logic [31:0] retry_initial;
    logic [31:0] backoff_max;
    logic [31:0] sample_period;

    // supervisor state
    logic        lk_initialized;
    logic        lk_online;
    t_link_phase lk_phase;
    logic [7:0]  lk_last_fault;
    logic [7:0]  lk_fault_total;
    logic [7:0]  lk_reinit_total;
    logic [31:0] lk_backoff;
    logic [31:0] lk_last_try;
    logic [31:0] lk_last_sample;
    logic [31:0] lk_offline_since;
    logic        lk_offline_held;
    logic [31:0] lk_update_count;

    t_result pending_reports[$];

    task automatic mark_offline(input logic [7:0] code, input logic [31:0] now);
        lk_online      = 1'b0;
        lk_initialized = 1'b0;
        lk_phase       = PHASE_BACKOFF;
        lk_last_fault  = code;
        if (lk_fault_total < COUNT_MAX) begin
            lk_fault_total = lk_fault_total + 8'd1;
        end
        if (!lk_offline_held) begin
            lk_offline_held  = 1'b1;
            lk_offline_since = now;
        end
        lk_update_count = lk_update_count + 32'd1;
    endtask

    task automatic try_init(input logic ok, input logic [7:0] err, output logic success);
        lk_phase = PHASE_INITING;
        if (!ok) begin
            lk_last_fault = err;
            success = 1'b0;
        end else begin
            lk_initialized   = 1'b1;
            lk_online        = 1'b1;
            lk_phase         = PHASE_ONLINE;
            lk_last_fault    = 8'd0;
            lk_backoff       = retry_initial;
            lk_offline_since = 32'd0;
            lk_offline_held  = 1'b0;
            if (lk_reinit_total < COUNT_MAX) begin
                lk_reinit_total = lk_reinit_total + 8'd1;
            end
            success = 1'b1;
        end
    endtask

    task automatic advance_supervisor(
        input  logic        cmd,
        input  logic [31:0] now,
        input  logic        iok,
        input  logic [7:0]  ierr,
        input  logic        rok,
        input  logic        pend,
        input  logic        done,
        output t_result     rep
    );
        logic        taken;
        logic        may_sample;
        logic [31:0] since_try;
        logic [31:0] since_sample;
        logic [32:0] doubled;
        t_runtime    rs;
        taken = 1'b0;
        if (cmd == CMD_FORCE) begin
            lk_initialized  = 1'b0;
            lk_online       = 1'b0;
            lk_phase        = PHASE_COLD;
            lk_last_try     = 32'd0;
            lk_backoff      = retry_initial;
            lk_update_count = lk_update_count + 32'd1;
            try_init(iok, ierr, may_sample);
        end else begin
            may_sample = lk_initialized;
            since_try  = now - lk_last_try;
            if (!lk_initialized && since_try >= lk_backoff) begin
                lk_last_try = now;
                try_init(iok, ierr, may_sample);
                if (!may_sample) begin
                    mark_offline(lk_last_fault, now);
                    if (lk_backoff < backoff_max) begin
                        doubled = {1'b0, lk_backoff} << 1;
                        if (doubled > {1'b0, backoff_max}) begin
                            doubled = {1'b0, backoff_max};
                        end
                        lk_backoff = doubled[31:0];
                    end
                end
            end
            since_sample = now - lk_last_sample;
            if (may_sample && since_sample >= sample_period) begin
                if (!rok) begin
                    mark_offline(READ_FAIL_CODE, now);
                end else begin
                    lk_online       = 1'b1;
                    lk_last_fault   = 8'd0;
                    lk_last_sample  = now;
                    lk_update_count = lk_update_count + 32'd1;
                    taken           = 1'b1;
                end
            end
        end

        if (lk_phase == PHASE_INITING) begin
            rs = RT_INITING;
        end else if (lk_phase == PHASE_BACKOFF) begin
            if (lk_fault_total >= FATAL_FAULTS && lk_backoff >= backoff_max) begin
                rs = RT_FATAL;
            end else begin
                rs = RT_BACKOFF;
            end
        end else if (lk_phase != PHASE_ONLINE || !lk_online) begin
            rs = RT_UNINIT;
        end else if (pend) begin
            rs = RT_CALIBRATING;
        end else if (!done) begin
            rs = RT_DEGRADED;
        end else begin
            rs = RT_READY;
        end

        rep.health_state     = rs;
        rep.link_online      = lk_online;
        rep.fault_code       = lk_last_fault;
        rep.faults_seen      = lk_fault_total;
        rep.reinits_seen     = lk_reinit_total;
        rep.backoff_now_ms   = lk_backoff;
        rep.offline_stamp_ms = lk_offline_since;
        rep.sample_taken     = taken;
        rep.publish_seq      = lk_update_count;
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
            o_fail_count = o_fail_count + 1;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            retry_initial    = RETRY_INITIAL_RST;
            backoff_max      = BACKOFF_MAX_RST;
            sample_period    = SAMPLE_PERIOD_RST;
            lk_initialized   = 1'b0;
            lk_online        = 1'b0;
            lk_phase         = PHASE_COLD;
            lk_last_fault    = 8'd0;
            lk_fault_total   = 8'd0;
            lk_reinit_total  = 8'd0;
            lk_backoff       = RETRY_INITIAL_RST;
            lk_last_try      = 32'd0;
            lk_last_sample   = 32'd0;
            lk_offline_since = 32'd0;
            lk_offline_held  = 1'b0;
            lk_update_count  = 32'd0;
            pending_reports.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pending_reports.size() == 0) begin
                    $error("result transfer with no input transfer waiting for it");
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = pending_reports.pop_front();
                    check_field("health_state", 32'(want.health_state),
                                32'(i_health_state));
                    check_field("link_online", 32'(want.link_online), 32'(i_link_online));
                    check_field("fault_code", 32'(want.fault_code), 32'(i_fault_code));
                    check_field("faults_seen", 32'(want.faults_seen), 32'(i_faults_seen));
                    check_field("reinits_seen", 32'(want.reinits_seen),
                                32'(i_reinits_seen));
                    check_field("backoff_now_ms", want.backoff_now_ms, i_backoff_now_ms);
                    check_field("offline_stamp_ms", want.offline_stamp_ms,
                                i_offline_stamp_ms);
                    check_field("sample_taken", 32'(want.sample_taken),
                                32'(i_sample_taken));
                    check_field("publish_seq", want.publish_seq, i_publish_seq);
                    o_checked = o_checked + 1;
                    if (want.health_state == RT_FATAL) begin
                        o_fatal_reports = o_fatal_reports + 1;
                    end
                    if (want.sample_taken) begin
                        o_samples = o_samples + 1;
                    end
                end
            end
            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    CFG_IDX_RETRY_INITIAL: begin
                        retry_initial = i_cfg_wdata;
                    end
                    CFG_IDX_BACKOFF_MAX: begin
                        backoff_max = i_cfg_wdata;
                    end
                    CFG_IDX_SAMPLE_PERIOD: begin
                        sample_period = i_cfg_wdata;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                advance_supervisor(i_command, i_now_ms, i_init_ok, i_init_error, i_read_ok,
                                   i_cal_pending, i_cal_done, want);
                pending_reports.push_back(want);
            end
        end
        o_outstanding = pending_reports.size();
    end

endmodule

@@ tb/tb_sensor_link_supervisor_backoff_top.sv @@
module tb_sensor_link_supervisor_backoff_top;
    timeunit 1ns;
    timeprecision 1ps;

    import slsb_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int LONG_HOLD   = 80;

    logic        i_clk;
    logic        rst_n       = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [1:0]  cfg_addr    = CFG_IDX_RETRY_INITIAL;
    logic [31:0] cfg_wdata   = 32'd0;
    logic        in_valid    = 1'b0;
    logic        in_stall;
    logic        command     = CMD_TICK;
    logic [31:0] now_ms      = 32'd0;
    logic        init_ok     = 1'b0;
    logic [7:0]  init_error  = 8'd0;
    logic        read_ok     = 1'b0;
    logic        cal_pending = 1'b0;
    logic        cal_done    = 1'b0;
    logic        out_valid;
    logic        out_stall   = 1'b0;
    logic [2:0]  health_state;
    logic        link_online;
    logic [7:0]  fault_code;
    logic [7:0]  faults_seen;
    logic [7:0]  reinits_seen;
    logic [31:0] backoff_now_ms;
    logic [31:0] offline_stamp_ms;
    logic        sample_taken;
    logic [31:0] publish_seq;

    int          fail_count;
    int          outstanding;
    int          checked;
    int          fatal_reports;
    int          samples;

    logic        quiet         = 1'b0;
    int          hold_requests = 0;
    int          holds_done    = 0;
    int          settings_used = 0;
    int          cycle_count   = 0;
    logic [31:0] now_track     = 32'd0;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    sensor_link_supervisor_backoff_top dut (
        .i_clk              (i_clk),
        .i_rst_n            (rst_n),
        .i_cfg_wr_en        (cfg_wr_en),
        .i_cfg_addr         (cfg_addr),
        .i_cfg_wdata        (cfg_wdata),
        .i_in_valid         (in_valid),
        .o_in_stall         (in_stall),
        .i_command          (command),
        .i_now_ms           (now_ms),
        .i_init_ok          (init_ok),
        .i_init_error       (init_error),
        .i_read_ok          (read_ok),
        .i_cal_pending      (cal_pending),
        .i_cal_done         (cal_done),
        .o_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .o_health_state     (health_state),
        .o_link_online      (link_online),
        .o_fault_code       (fault_code),
        .o_faults_seen      (faults_seen),
        .o_reinits_seen     (reinits_seen),
        .o_backoff_now_ms   (backoff_now_ms),
        .o_offline_stamp_ms (offline_stamp_ms),
        .o_sample_taken     (sample_taken),
        .o_publish_seq      (publish_seq)
    );

    slsb_supervisor_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (rst_n),
        .i_cfg_wr_en        (cfg_wr_en),
        .i_cfg_addr         (cfg_addr),
        .i_cfg_wdata        (cfg_wdata),
        .i_in_valid         (in_valid),
        .i_in_stall         (in_stall),
        .i_command          (command),
        .i_now_ms           (now_ms),
        .i_init_ok          (init_ok),
        .i_init_error       (init_error),
        .i_read_ok          (read_ok),
        .i_cal_pending      (cal_pending),
        .i_cal_done         (cal_done),
        .i_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .i_health_state     (health_state),
        .i_link_online      (link_online),
        .i_fault_code       (fault_code),
        .i_faults_seen      (faults_seen),
        .i_reinits_seen     (reinits_seen),
        .i_backoff_now_ms   (backoff_now_ms),
        .i_offline_stamp_ms (offline_stamp_ms),
        .i_sample_taken     (sample_taken),
        .i_publish_seq      (publish_seq),
        .o_fail_count       (fail_count),
        .o_outstanding      (outstanding),
        .o_checked          (checked),
        .o_fatal_reports    (fatal_reports),
        .o_samples          (samples)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     outstanding);
            $display("Verification failed");
            $finish;
        end
    end

    // result side: random hold-off bursts, plus one long hold on request
    initial begin
        int gap;
        forever begin
            @(negedge i_clk);
            if (holds_done != hold_requests) begin
                holds_done = holds_done + 1;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge i_clk);
                out_stall <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                gap = $urandom_range(1, 13);
                out_stall <= 1'b1;
                repeat (gap) @(negedge i_clk);
                out_stall <= 1'b0;
            end
        end
    end

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_item(input logic cmd, input logic [31:0] now, input logic iok,
                             input logic [7:0] ierr, input logic rok, input logic pend,
                             input logic done);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        in_valid    <= 1'b1;
        command     <= cmd;
        now_ms      <= now;
        init_ok     <= iok;
        init_error  <= ierr;
        read_ok     <= rok;
        cal_pending <= pend;
        cal_done    <= done;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // write enable stays high across back-to-back writes
    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(negedge i_clk);
        while (outstanding != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic load_settings(input logic [31:0] retry, input logic [31:0] cap,
                                 input logic [31:0] period);
        wait_drained();
        cfg_write(CFG_IDX_RETRY_INITIAL, retry);
        cfg_write(CFG_IDX_BACKOFF_MAX, cap);
        cfg_write(CFG_IDX_SAMPLE_PERIOD, period);
        cfg_wr_en <= 1'b0;
        settings_used = settings_used + 1;
    endtask

    // mostly forward-moving time stamps, with occasional jumps anywhere
    task automatic run_traffic(input int count, input int unsigned step_max,
                               input int unsigned iok_pct, input int unsigned rok_pct);
        logic cmd;
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(0, 15))
                0: begin
                    now_track = $urandom();
                end
                1: begin
                    now_track = now_track + ($urandom() >> $urandom_range(0, 31));
                end
                default: begin
                    now_track = now_track + $urandom_range(0, step_max);
                end
            endcase
            cmd = ($urandom_range(0, 11) == 0) ? CMD_FORCE : CMD_TICK;
            send_item(cmd, now_track, $urandom_range(0, 99) < iok_pct, 8'($urandom()),
                      $urandom_range(0, 99) < rok_pct, 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;
        @(negedge i_clk);

        // wrap-around stamps, forced restarts, offline at time zero, all online states
        load_settings(32'd1000, 32'd60000, 32'd0);
        send_item(CMD_TICK, 32'd0, 1'b1, 8'h00, 1'b1, 1'b0, 1'b1);
        send_item(CMD_TICK, 32'd1000, 1'b0, 8'hFF, 1'b1, 1'b0, 1'b1);
        send_item(CMD_FORCE, 32'd5, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0);
        send_item(CMD_FORCE, 32'd0, 1'b1, 8'h5A, 1'b1, 1'b1, 1'b1);
        send_item(CMD_TICK, 32'd0, 1'b1, 8'h00, 1'b0, 1'b0, 1'b1);
        send_item(CMD_TICK, 32'hFFFF_FFFF, 1'b1, 8'h00, 1'b1, 1'b1, 1'b0);
        send_item(CMD_TICK, 32'hFFFF_FFFF, 1'b1, 8'h00, 1'b1, 1'b0, 1'b0);
        send_item(CMD_TICK, 32'd0, 1'b1, 8'h00, 1'b1, 1'b0, 1'b1);
        send_item(CMD_TICK, 32'd1, 1'b1, 8'h00, 1'b1, 1'b1, 1'b1);

        // repeated failures up to the cap and into fatal, then recovery
        load_settings(32'd1, 32'd4, 32'hFFFF_FFFF);
        send_item(CMD_FORCE, 32'd100, 1'b0, 8'h3C, 1'b1, 1'b0, 1'b0);
        for (int k = 1; k <= 10; k++) begin
            send_item(CMD_TICK, 32'd100 + 32'(10 * k), 1'b0, 8'(8'h80 >> (k % 8)), 1'b1,
                      1'b0, 1'b0);
        end
        send_item(CMD_TICK, 32'd300, 1'b1, 8'h00, 1'b1, 1'b0, 1'b1);

        // doubling saturates and clamps, then a failure at the cap
        load_settings(32'hC000_0000, 32'hFFFF_FFFF, 32'd0);
        send_item(CMD_FORCE, 32'd0, 1'b0, 8'h01, 1'b1, 1'b0, 1'b0);
        send_item(CMD_TICK, 32'hC000_0000, 1'b0, 8'h02, 1'b1, 1'b0, 1'b0);
        send_item(CMD_TICK, 32'hBFFF_FFFF, 1'b0, 8'h04, 1'b1, 1'b0, 1'b0);

        load_settings(32'd3, 32'd40, 32'd4);
        hold_requests = hold_requests + 1;
        run_traffic(190, 12, 60, 80);

        load_settings(32'd1, 32'd2, 32'd0);
        run_traffic(180, 3, 30, 40);

        load_settings(32'd0, 32'd16, 32'd2);
        run_traffic(170, 4, 70, 30);

        load_settings(32'd40, 32'd1, 32'd10);
        run_traffic(170, 40, 50, 70);

        load_settings($urandom_range(1, 100), $urandom_range(1, 2000), $urandom_range(0, 30));
        run_traffic(170, 200, 60, 80);

        load_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        run_traffic(40, 1000, 60, 80);

        load_settings(32'd2, 32'hFFFF_FFFF, 32'd1);
        quiet = 1'b1;
        run_traffic(160, 30, 60, 80);

        in_valid <= 1'b0;
        @(negedge i_clk);
        while (outstanding != 0) @(negedge i_clk);
        repeat (5) @(negedge i_clk);

        $display("checked %0d results under %0d register settings, with one long output hold",
                 checked, settings_used);
        $display("saw %0d fatal reports and %0d accepted samples", fatal_reports, samples);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
